[rtl/core/irpd_pkg.sv]
// ----------------------------------------------------------------------------
// irpd_pkg
// shared types and constants of the infrared pulse-distance frame decoder
// ----------------------------------------------------------------------------
package irpd_pkg;

    localparam int TICK_W     = 18;
    localparam int CODE_OUT_W = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // register indexes, byte address is 4 * index
    localparam logic [REG_IDX_W-1:0] REG_LEADER_MIN    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEADER_MAX    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BIT_MIN       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BIT_MAX       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ONE_THRESHOLD = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_MIN    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_MAX    = 3'd6;

    // register reset values in ticks
    localparam logic [TICK_W-1:0] RST_LEADER_MIN    = 18'd12500;
    localparam logic [TICK_W-1:0] RST_LEADER_MAX    = 18'd14285;
    localparam logic [TICK_W-1:0] RST_BIT_MIN       = 18'd1000;
    localparam logic [TICK_W-1:0] RST_BIT_MAX       = 18'd3333;
    localparam logic [TICK_W-1:0] RST_ONE_THRESHOLD = 18'd2000;
    localparam logic [TICK_W-1:0] RST_REPEAT_MIN    = 18'd80000;
    localparam logic [TICK_W-1:0] RST_REPEAT_MAX    = 18'd150000;

    typedef struct packed {
        logic [TICK_W-1:0] leader_min;
        logic [TICK_W-1:0] leader_max;
        logic [TICK_W-1:0] bit_min;
        logic [TICK_W-1:0] bit_max;
        logic [TICK_W-1:0] one_threshold;
        logic [TICK_W-1:0] repeat_min;
        logic [TICK_W-1:0] repeat_max;
    } cfg_t;

    // window hits of one interval
    typedef struct packed {
        logic leader_hit;
        logic bit_hit;
        logic bit_one;
        logic repeat_hit;
    } class_t;

    // result of one decode step
    typedef struct packed {
        logic emit;
        logic from_repeat;
    } emit_t;

endpackage

[rtl/core/irpd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// irpd_cfg_regs
// apb register file holding the interval windows and the one threshold
// ----------------------------------------------------------------------------
module irpd_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [irpd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [irpd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [irpd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output irpd_pkg::cfg_t                  cfg
);
    import irpd_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [TICK_W-1:0]    wr_value;
    logic [TICK_W-1:0]    rd_value;
    logic                 wr_en;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[APB_ADDR_W-1:2];
    assign wr_value = pwdata[TICK_W-1:0];
    assign wr_en    = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.leader_min    <= RST_LEADER_MIN;
            cfg_reg.leader_max    <= RST_LEADER_MAX;
            cfg_reg.bit_min       <= RST_BIT_MIN;
            cfg_reg.bit_max       <= RST_BIT_MAX;
            cfg_reg.one_threshold <= RST_ONE_THRESHOLD;
            cfg_reg.repeat_min    <= RST_REPEAT_MIN;
            cfg_reg.repeat_max    <= RST_REPEAT_MAX;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LEADER_MIN:    cfg_reg.leader_min    <= wr_value;
                REG_LEADER_MAX:    cfg_reg.leader_max    <= wr_value;
                REG_BIT_MIN:       cfg_reg.bit_min       <= wr_value;
                REG_BIT_MAX:       cfg_reg.bit_max       <= wr_value;
                REG_ONE_THRESHOLD: cfg_reg.one_threshold <= wr_value;
                REG_REPEAT_MIN:    cfg_reg.repeat_min    <= wr_value;
                REG_REPEAT_MAX:    cfg_reg.repeat_max    <= wr_value;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LEADER_MIN:    rd_value = cfg_reg.leader_min;
            REG_LEADER_MAX:    rd_value = cfg_reg.leader_max;
            REG_BIT_MIN:       rd_value = cfg_reg.bit_min;
            REG_BIT_MAX:       rd_value = cfg_reg.bit_max;
            REG_ONE_THRESHOLD: rd_value = cfg_reg.one_threshold;
            REG_REPEAT_MIN:    rd_value = cfg_reg.repeat_min;
            REG_REPEAT_MAX:    rd_value = cfg_reg.repeat_max;
            default:           rd_value = '0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-TICK_W){1'b0}}, rd_value};
    assign cfg    = cfg_reg;

endmodule

[rtl/core/irpd_classify.sv]
// ----------------------------------------------------------------------------
// irpd_classify
// window compares of one edge interval
// ----------------------------------------------------------------------------
module irpd_classify (
    input  logic [irpd_pkg::TICK_W-1:0] interval,
    input  irpd_pkg::cfg_t              cfg,
    output irpd_pkg::class_t            cls
);
    import irpd_pkg::*;

    // all windows are open on both ends
    assign cls.leader_hit = (interval > cfg.leader_min) && (interval < cfg.leader_max);
    assign cls.bit_hit    = (interval > cfg.bit_min) && (interval < cfg.bit_max);
    assign cls.bit_one    = (interval >= cfg.one_threshold);
    assign cls.repeat_hit = (interval > cfg.repeat_min) && (interval < cfg.repeat_max);

endmodule

[rtl/core/irpd_assembler.sv]
// ----------------------------------------------------------------------------
// irpd_assembler
// frame state, bit counter and code word assembly
// ----------------------------------------------------------------------------
module irpd_assembler #(
    parameter int FRAME_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  irpd_pkg::class_t      cls,
    output irpd_pkg::emit_t       res,
    output logic [FRAME_BITS-1:0] code
);
    import irpd_pkg::*;

    localparam int IDX_W = $clog2(FRAME_BITS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BITS - 1);

    logic                  in_frame_reg, in_frame_next;
    logic [IDX_W-1:0]      bit_index_reg, bit_index_next;
    logic [FRAME_BITS-1:0] code_reg, code_next;
    logic                  start;
    logic                  frame_now;
    logic                  take_bit;
    logic                  last_bit;
    logic [IDX_W-1:0]      idx_eff;
    logic [IDX_W-1:0]      bit_pos;

    always_comb begin
        start     = !in_frame_reg && cls.leader_hit;
        frame_now = in_frame_reg || start;
        idx_eff   = start ? '0 : bit_index_reg;
        take_bit  = frame_now && cls.bit_hit;
        last_bit  = take_bit && (idx_eff == LAST_IDX);
        // first received bit lands in the top bit
        bit_pos   = LAST_IDX - idx_eff;

        code_next = code_reg;
        if (take_bit) begin
            code_next[bit_pos] = cls.bit_one;
        end

        in_frame_next  = frame_now;
        bit_index_next = idx_eff;
        if (last_bit) begin
            in_frame_next  = 1'b0;
            bit_index_next = '0;
        end else if (take_bit) begin
            bit_index_next = idx_eff + 1'b1;
        end

        res.emit        = last_bit || cls.repeat_hit;
        res.from_repeat = !last_bit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg  <= 1'b0;
            bit_index_reg <= '0;
            code_reg      <= '0;
        end else if (step) begin
            in_frame_reg  <= in_frame_next;
            bit_index_reg <= bit_index_next;
            code_reg      <= code_next;
        end
    end

    assign code = code_next;

endmodule

[rtl/core/ir_pulse_distance_frame_decoder_unit.sv]
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder_unit
// pulse-distance infrared remote frame decoder, one item per falling edge
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one item per falling edge of the received signal, the tick
//   count since the previous falling edge (saturated by the timer).
//   m_ channel: one item per completed frame (from_repeat low) or per repeat
//   interval (from_repeat high), carrying the assembled code word.
//   apb port: seven 18-bit window and threshold registers at 4 * index;
//   write them only while no item is in flight.
// pipeline
//   an item accepted into the input register is decoded once the result slot
//   is free; its result, if any, is registered in the stage that drives m_valid.
//   one item per cycle sustained while m_ready holds high: the window compares
//   and the bit insert sit between the input register and the result register.
// reset
//   synchronous, active low: decoder goes idle, code word cleared,
//   registers return to their default windows.
// stall
//   while m_valid waits on m_ready the input register holds one more item;
//   s_ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder_unit #(
    parameter int FRAME_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input item channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [irpd_pkg::TICK_W-1:0]     s_edge_interval,
    // result item channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [irpd_pkg::CODE_OUT_W-1:0] m_frame_code,
    output logic                            m_from_repeat,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [irpd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [irpd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [irpd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import irpd_pkg::*;

    cfg_t                  cfg;
    class_t                cls;
    emit_t                 res;
    logic [FRAME_BITS-1:0] code;
    logic [CODE_OUT_W-1:0] code_out;

    // input stage
    logic                  in_valid_reg;
    logic [TICK_W-1:0]     in_interval_reg;

    // result stage
    logic                  out_valid_reg;
    logic [CODE_OUT_W-1:0] out_code_reg;
    logic                  out_repeat_reg;

    logic                  out_free;
    logic                  step;

    irpd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the result slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_ready;
    // the held item is decoded once its result, if any, has a place to go
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_interval_reg <= s_edge_interval;
        end
    end

    irpd_classify u_classify (
        .interval (in_interval_reg),
        .cfg      (cfg),
        .cls      (cls)
    );

    irpd_assembler #(
        .FRAME_BITS (FRAME_BITS)
    ) u_assembler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cls     (cls),
        .res     (res),
        .code    (code)
    );

    // only the low word of a longer frame leaves the block, a shorter one is zero-extended
    generate
        if (FRAME_BITS >= CODE_OUT_W) begin : g_code_trunc
            assign code_out = code[CODE_OUT_W-1:0];
        end else begin : g_code_ext
            assign code_out = {{(CODE_OUT_W-FRAME_BITS){1'b0}}, code};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && res.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res.emit) begin
            out_code_reg   <= code_out;
            out_repeat_reg <= res.from_repeat;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_frame_code  = out_code_reg;
    assign m_from_repeat = out_repeat_reg;

endmodule

[sim/ir_pulse_distance_frame_decoder_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder_unit_tb
// self-checking bench for the pulse-distance infrared frame decoder: edge
// intervals go in over the s_ channel and decoded codes come back over the
// m_ channel. A scoreboard tracks the leader, bit and repeat windows, predicts
// every code item and compares it field by field. The run steps through
// several window settings written over apb: reset values, ordered, overlapping,
// wide open, dead and single-value windows.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder_unit_tb;

    import irpd_pkg::*;

    localparam int NUM_REGS     = 7;
    localparam int PAD_W        = APB_DATA_W - TICK_W;
    localparam int RANDOM_ITEMS = 800;
    localparam int PHASE_ITEMS  = 90;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS   = 1_000_000;

    localparam logic [TICK_W-1:0]    TICK_MAX   = '1;
    // address slot past the last register, writes there must be ignored
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // window settings that the run goes through
    typedef enum int {
        SET_DEFAULT,
        SET_ORDERED,
        SET_OVERLAP,
        SET_WIDE,
        SET_DEAD,
        SET_NARROW
    } window_mode_t;

    typedef struct packed {
        logic [CODE_OUT_W-1:0] frame_code;
        logic                  from_repeat;
    } code_item_t;

    // ------------------------------------------------------------------------
    // scoreboard: mirror of the windows and the frame state, queue of codes
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [TICK_W-1:0]     regs [NUM_REGS];
        bit                    in_frame;
        int unsigned           bit_pos;
        logic [CODE_OUT_W-1:0] code_word;
        code_item_t            expected_codes [$];
        int unsigned           errors;

        function new();
            regs[REG_LEADER_MIN]    = RST_LEADER_MIN;
            regs[REG_LEADER_MAX]    = RST_LEADER_MAX;
            regs[REG_BIT_MIN]       = RST_BIT_MIN;
            regs[REG_BIT_MAX]       = RST_BIT_MAX;
            regs[REG_ONE_THRESHOLD] = RST_ONE_THRESHOLD;
            regs[REG_REPEAT_MIN]    = RST_REPEAT_MIN;
            regs[REG_REPEAT_MAX]    = RST_REPEAT_MAX;
            in_frame  = 1'b0;
            bit_pos   = 0;
            code_word = '0;
            errors    = 0;
        endfunction

        function void write_reg(input int unsigned idx, input logic [APB_DATA_W-1:0] data);
            if (idx < NUM_REGS) regs[idx] = data[TICK_W-1:0];
        endfunction

        function bit in_window(input logic [TICK_W-1:0] t, input logic [TICK_W-1:0] lo,
                               input logic [TICK_W-1:0] hi);
            return (t > lo) && (t < hi);
        endfunction

        // one accepted edge interval: leader, bit and repeat tests in turn
        function void note_interval(input logic [TICK_W-1:0] t);
            bit frame_done;
            frame_done = 1'b0;
            if (!in_frame && in_window(t, regs[REG_LEADER_MIN], regs[REG_LEADER_MAX])) begin
                in_frame = 1'b1;
                bit_pos  = 0;
            end
            if (in_frame && in_window(t, regs[REG_BIT_MIN], regs[REG_BIT_MAX])) begin
                code_word[CODE_OUT_W-1-bit_pos] = (t >= regs[REG_ONE_THRESHOLD]);
                bit_pos++;
                if (bit_pos >= CODE_OUT_W) begin
                    frame_done = 1'b1;
                    in_frame   = 1'b0;
                    bit_pos    = 0;
                    expected_codes.push_back('{frame_code: code_word, from_repeat: 1'b0});
                end
            end
            if (!frame_done && in_window(t, regs[REG_REPEAT_MIN], regs[REG_REPEAT_MAX]))
                expected_codes.push_back('{frame_code: code_word, from_repeat: 1'b1});
        endfunction

        function void check_result(input logic [CODE_OUT_W-1:0] code, input logic rep);
            code_item_t exp_item;
            if (expected_codes.size() == 0) begin
                $error("unexpected code item: frame_code %h from_repeat %b", code, rep);
                errors++;
                return;
            end
            exp_item = expected_codes.pop_front();
            if (code !== exp_item.frame_code) begin
                $error("frame_code expected %h actual %h", exp_item.frame_code, code);
                errors++;
            end
            if (rep !== exp_item.from_repeat) begin
                $error("from_repeat expected %b actual %b", exp_item.from_repeat, rep);
                errors++;
            end
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // dut signals, every input known from time zero
    // ------------------------------------------------------------------------
    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [TICK_W-1:0]     s_edge_interval = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [CODE_OUT_W-1:0] m_frame_code;
    logic                  m_from_repeat;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0] paddr           = '0;
    logic [APB_DATA_W-1:0] pwdata          = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ir_pulse_distance_frame_decoder_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_edge_interval (s_edge_interval),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_code    (m_frame_code),
        .m_from_repeat   (m_from_repeat),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    frame_scoreboard sb = new();

    // window values of the current setting, used to aim the stimulus
    logic [TICK_W-1:0] setting [NUM_REGS];
    int unsigned       items_sent  = 0;
    int unsigned       burst_left  = 0;
    int unsigned       reg_errors  = 0;
    // set once by the stimulus to ask the receiver for its long hold-off
    logic              hold_req    = 1'b0;

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // hard stop in case the decoder hangs or drops a code item
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // sample both channels at the rising edge, values are settled by then
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_interval(s_edge_interval);
            if (m_valid && m_ready) sb.check_result(m_frame_code, m_from_repeat);
        end
    end

    // receiver: stall pattern of its own, plus one long hold-off on request
    initial begin
        int unsigned rx_mode;
        int unsigned mode_left;
        int unsigned hold_left;
        bit          hold_done;
        logic        nxt;
        rx_mode   = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                nxt = 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 128);
                end
                mode_left--;
                case (rx_mode)
                    0: nxt = 1'b1;
                    1: nxt = 1'($urandom_range(0, 1));
                    2: nxt = ($urandom_range(0, 3) == 0);
                    default: nxt = ~m_ready;
                endcase
            end
            m_ready <= nxt;
        end
    end

    // ------------------------------------------------------------------------
    // value pickers
    // ------------------------------------------------------------------------
    function automatic logic [TICK_W-1:0] clamp_tick(input int v);
        if (v < 0) return '0;
        if (v > int'(TICK_MAX)) return TICK_MAX;
        return v[TICK_W-1:0];
    endfunction

    // strictly inside the window, or any value when the window is empty
    function automatic logic [TICK_W-1:0] pick_inside(input logic [TICK_W-1:0] lo,
                                                      input logic [TICK_W-1:0] hi);
        if (int'(hi) > int'(lo) + 1) return TICK_W'($urandom_range(int'(lo) + 1, int'(hi) - 1));
        return TICK_W'($urandom());
    endfunction

    // bit interval aimed at a one or a zero where the threshold allows it
    function automatic logic [TICK_W-1:0] pick_bit(input bit want_one);
        int lo;
        int hi;
        int th;
        int a;
        int b;
        lo = int'(setting[REG_BIT_MIN]);
        hi = int'(setting[REG_BIT_MAX]);
        th = int'(setting[REG_ONE_THRESHOLD]);
        if (want_one) begin
            a = (th > lo + 1) ? th : lo + 1;
            b = hi - 1;
        end else begin
            a = lo + 1;
            b = (th - 1 < hi - 1) ? th - 1 : hi - 1;
        end
        if (a <= b) return TICK_W'($urandom_range(a, b));
        return pick_inside(setting[REG_BIT_MIN], setting[REG_BIT_MAX]);
    endfunction

    // anything: random, field extremes, or at or one off a register value
    function automatic logic [TICK_W-1:0] pick_noise();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) return TICK_W'($urandom());
        if (r == 1) return $urandom_range(0, 1) ? TICK_MAX : '0;
        return clamp_tick(int'(setting[$urandom_range(0, NUM_REGS - 1)])
                          + $urandom_range(0, 2) - 1);
    endfunction

    function automatic logic [TICK_W-1:0] pick_repeat();
        return pick_inside(setting[REG_REPEAT_MIN], setting[REG_REPEAT_MAX]);
    endfunction

    // ------------------------------------------------------------------------
    // input channel driving, changes at the falling edge
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [TICK_W-1:0] t);
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_edge_interval <= t;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_gap(input int unsigned n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // one item with bursty spacing
    task automatic put(input logic [TICK_W-1:0] t);
        if (burst_left == 0) begin
            idle_gap($urandom_range(1, 6));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_item(t);
        items_sent++;
    endtask

    // stop offering and wait for every code item, then for the pipe to empty
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // apb port, back to back transfers, idle only at the end of a group
    // ------------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
    endtask

    task automatic apb_idle();
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write the whole setting (junk above bit 17 now and then), poke the
    // unused slot, then read everything back
    task automatic apply_setting();
        logic [APB_DATA_W-1:0] wdata;
        logic [APB_DATA_W-1:0] rdata;
        for (int i = 0; i < NUM_REGS; i++) begin
            wdata = {($urandom_range(0, 3) == 0) ? PAD_W'($urandom()) : PAD_W'(0), setting[i]};
            apb_access(1'b1, REG_IDX_W'(i), wdata, rdata);
            sb.write_reg(i, wdata);
        end
        wdata = $urandom();
        apb_access(1'b1, REG_UNUSED, wdata, rdata);
        sb.write_reg(REG_UNUSED, wdata);
        for (int i = 0; i < NUM_REGS; i++) begin
            apb_access(1'b0, REG_IDX_W'(i), '0, rdata);
            if (rdata[TICK_W-1:0] !== setting[i]) begin
                $error("register %0d expected %h actual %h", i, setting[i], rdata[TICK_W-1:0]);
                reg_errors++;
            end
        end
        apb_idle();
    endtask

    // ------------------------------------------------------------------------
    // window settings
    // ------------------------------------------------------------------------
    task automatic choose_setting(input window_mode_t mode);
        int b0, b1, th, l0, l1, r0, r1, sel;
        case (mode)
            SET_ORDERED: begin
                // bit, leader, repeat windows apart from each other
                b0 = $urandom_range(0, 40000);
                b1 = b0 + $urandom_range(2, 20000);
                th = $urandom_range(b0, b1 + 1);
                l0 = b1 + $urandom_range(0, 30000);
                l1 = l0 + $urandom_range(2, 20000);
                r0 = l1 + $urandom_range(0, 60000);
                r1 = r0 + $urandom_range(2, 100000);
            end
            SET_OVERLAP: begin
                // leader overlaps bit window, repeat often covers it too
                b0 = $urandom_range(0, 100000);
                b1 = b0 + $urandom_range(3, 50000);
                th = $urandom_range(b0, b1);
                l0 = b0 + $urandom_range(0, (b1 - b0) / 2);
                l1 = b1 + $urandom_range(0, 2000);
                if ($urandom_range(0, 1)) begin
                    r0 = b0;
                    r1 = b1;
                end else begin
                    r0 = $urandom_range(b0, b1);
                    r1 = r0 + $urandom_range(2, 100000);
                end
            end
            SET_WIDE: begin
                // everything but the field extremes is a bit, repeat inverted
                b0  = 0;
                b1  = int'(TICK_MAX);
                l0  = $urandom_range(0, 1) ? 0 : $urandom_range(0, 100000);
                l1  = int'(TICK_MAX);
                sel = $urandom_range(0, 2);
                th  = (sel == 0) ? 0 : (sel == 1) ? int'(TICK_MAX) : $urandom_range(1, 262142);
                r0  = int'(TICK_MAX);
                r1  = 0;
            end
            SET_DEAD: begin
                // no window can match: all zero, all max, or inverted
                sel = $urandom_range(0, 2);
                if (sel == 0) begin
                    b0 = 0; b1 = 0; th = 0; l0 = 0; l1 = 0; r0 = 0; r1 = 0;
                end else if (sel == 1) begin
                    b0 = int'(TICK_MAX); b1 = int'(TICK_MAX); th = int'(TICK_MAX);
                    l0 = int'(TICK_MAX); l1 = int'(TICK_MAX);
                    r0 = int'(TICK_MAX); r1 = int'(TICK_MAX);
                end else begin
                    b0 = $urandom_range(0, TICK_MAX);
                    b1 = $urandom_range(0, b0 + 1);
                    l0 = $urandom_range(0, TICK_MAX);
                    l1 = $urandom_range(0, l0 + 1);
                    r0 = $urandom_range(0, TICK_MAX);
                    r1 = $urandom_range(0, r0 + 1);
                    th = $urandom_range(0, TICK_MAX);
                end
            end
            SET_NARROW: begin
                // each window lets exactly one value through
                b0 = $urandom_range(0, 100000);
                b1 = b0 + 2;
                th = b0 + 1 + $urandom_range(0, 1);
                l0 = b1 + $urandom_range(0, 20000);
                l1 = l0 + 2;
                r0 = l1 + $urandom_range(0, 50000);
                r1 = r0 + 2;
            end
            default: begin
                b0 = int'(RST_BIT_MIN);
                b1 = int'(RST_BIT_MAX);
                th = int'(RST_ONE_THRESHOLD);
                l0 = int'(RST_LEADER_MIN);
                l1 = int'(RST_LEADER_MAX);
                r0 = int'(RST_REPEAT_MIN);
                r1 = int'(RST_REPEAT_MAX);
            end
        endcase
        setting[REG_LEADER_MIN]    = clamp_tick(l0);
        setting[REG_LEADER_MAX]    = clamp_tick(l1);
        setting[REG_BIT_MIN]       = clamp_tick(b0);
        setting[REG_BIT_MAX]       = clamp_tick(b1);
        setting[REG_ONE_THRESHOLD] = clamp_tick(th);
        setting[REG_REPEAT_MIN]    = clamp_tick(r0);
        setting[REG_REPEAT_MAX]    = clamp_tick(r1);
    endtask

    // ------------------------------------------------------------------------
    // frame level stimulus
    // ------------------------------------------------------------------------
    // leader then nbits bits, a repeat slipped in mid-frame now and then
    task automatic send_frame(input int unsigned nbits);
        put(pick_inside(setting[REG_LEADER_MIN], setting[REG_LEADER_MAX]));
        for (int k = 0; k < nbits; k++) begin
            if ($urandom_range(0, 29) == 0) put(pick_repeat());
            put(pick_bit($urandom_range(0, 1)));
        end
    endtask

    task automatic run_sequence();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            // well-formed frame, then a few repeats
            send_frame(CODE_OUT_W);
            repeat ($urandom_range(0, 2)) put(pick_repeat());
        end else if (roll < 70) begin
            repeat ($urandom_range(1, 3)) put(pick_repeat());
        end else if (roll < 85) begin
            // frame cut short by junk
            send_frame($urandom_range(0, CODE_OUT_W - 1));
            put(pick_noise());
        end else begin
            repeat ($urandom_range(1, 4)) put(pick_noise());
        end
        if ($urandom_range(0, 15) == 0) drain();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        window_mode_t plan [8];
        window_mode_t mode;
        int unsigned  phase;
        int unsigned  phase_end;
        int unsigned  saved;

        plan = '{SET_ORDERED, SET_OVERLAP, SET_WIDE, SET_DEAD,
                 SET_NARROW, SET_ORDERED, SET_DEAD, SET_WIDE};
        choose_setting(SET_DEFAULT);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part on reset windows
        put(18'd100000);               // repeat before any frame gives zero
        put(18'd0);                    // field extremes, ignored
        put(TICK_MAX);
        put(RST_LEADER_MIN);           // window bounds are exclusive
        put(RST_LEADER_MAX);
        put(RST_REPEAT_MIN);
        put(RST_REPEAT_MAX);
        put(RST_LEADER_MIN + 1'b1);    // leader
        put(RST_BIT_MIN + 1'b1);       // lowest zero
        put(RST_BIT_MAX - 1'b1);       // highest one
        put(RST_ONE_THRESHOLD - 1'b1); // just below the threshold
        put(RST_ONE_THRESHOLD);        // threshold itself is a one
        put(RST_BIT_MIN);              // bit bounds, ignored
        put(RST_BIT_MAX);
        put(RST_REPEAT_MAX - 1'b1);    // repeat in the middle of a frame
        put(RST_REPEAT_MIN + 1'b1);
        put(RST_LEADER_MIN + 18'd100); // leader inside a frame does nothing
        put(18'd0);

        // reset windows written explicitly, then a long receiver hold-off
        // while repeats keep coming, so the decoder fills and stalls
        items_sent = 0;
        drain();
        apply_setting();
        hold_req = 1'b1;
        repeat (16) put(pick_repeat());
        phase_end = items_sent + PHASE_ITEMS;
        while (items_sent < phase_end) run_sequence();

        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            mode = plan[phase % 8];
            drain();
            choose_setting(mode);
            apply_setting();
            if (mode == SET_DEAD) begin
                // nothing matches here, these items do not use up the budget
                saved = items_sent;
                repeat (25) put(pick_noise());
                items_sent = saved;
            end else begin
                phase_end = items_sent + PHASE_ITEMS;
                while (items_sent < phase_end) run_sequence();
            end
            phase++;
        end

        drain();
        repeat (2 * DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && reg_errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
